[rtl/core/tlps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlps_pkg
// Shared types and widths for the tree LCA / path weight block.
// ----------------------------------------------------------------------------
package tlps_pkg;

  localparam int IdW  = 16;  // node id, depth and weight width
  localparam int PfxW = 32;  // prefix weight width
  localparam int SumW = 33;  // path sum width

  // one node-memory word
  typedef struct packed {
    logic [IdW-1:0]  own;
    logic [PfxW-1:0] prefix;
    logic [IdW-1:0]  depth;
  } node_rec_t;

endpackage

[rtl/core/tree_lca_path_weight_sum_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_lca_path_weight_sum_top
// Loads a rooted tree node by node into a node memory and a binary-lifting
// ancestor memory, and answers LCA / path weight queries from them.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o  | action, node_a, node_b,
//          |           |                        | parent_node, node_weight
//  out     | output    | out_valid_o/out_stall_i| common_ancestor, path_sum
//
//  The length of a load beat and of a query beat is set by the chain of dependent
//  registered reads of the ancestor and node memories, and in_stall_o holds the
//  input until the beat is done; a query ends sooner when the lifted endpoint
//  already meets the other.
//  Reset only clears the sequencer and the output valid; node 0 is a sentinel
//  that is never written and reads as all zeros through an address check.
//  A finished result waits in the output register; a new beat is taken while it
//  waits, and only the end of the next query holds until the register is free.
//
module tree_lca_path_weight_sum_top
  import tlps_pkg::*;
#(
  parameter int NODES       = 65536,
  parameter int LIFT_LEVELS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [IdW-1:0]    node_a_i,
  input  logic [IdW-1:0]    node_b_i,
  input  logic [IdW-1:0]    parent_node_i,
  input  logic [IdW-1:0]    node_weight_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IdW-1:0]    common_ancestor_o,
  output logic [SumW-1:0]   path_sum_o
);

  localparam int NW = $clog2(NODES);
  localparam int LW = $clog2(LIFT_LEVELS);
  localparam int AncDepth = 2 ** (NW + LW);
  localparam logic [LW-1:0] LvlTop = LW'(LIFT_LEVELS - 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LD_PAR = 4'd1;   // parent record arrives
  localparam logic [3:0] S_LD_ISS = 4'd2;   // read ancestor of current level
  localparam logic [3:0] S_LD_WR  = 4'd3;   // write next level entry
  localparam logic [3:0] S_Q_DEP  = 4'd4;   // endpoint records arrive
  localparam logic [3:0] S_Q_UP1  = 4'd5;   // lift candidate arrives
  localparam logic [3:0] S_Q_UP2  = 4'd6;   // candidate depth arrives
  localparam logic [3:0] S_Q_CMP  = 4'd7;
  localparam logic [3:0] S_Q_DN   = 4'd8;   // joint lifting
  localparam logic [3:0] S_Q_TOP  = 4'd9;   // parent of final pair
  localparam logic [3:0] S_Q_FIN  = 4'd10;  // LCA record arrives

  function automatic logic [NW-1:0] clamp_id(input logic [IdW-1:0] id);
    logic [31:0] w;
    w = 32'(id);
    return (w < 32'(NODES)) ? w[NW-1:0] : '0;
  endfunction

  function automatic logic [IdW-1:0] to_id(input logic [NW-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[IdW-1:0];
  endfunction

  // ---------------- memories ----------------
  node_rec_t        nd_mem [NODES];
  logic [IdW-1:0]   an_mem [AncDepth];

  logic             nd_we;
  logic [NW-1:0]    nd_wa, nd_ra0, nd_ra1;
  node_rec_t        nd_wd, nd_rd0_q, nd_rd1_q, nd0, nd1;
  logic             nd_z0_q, nd_z1_q;

  logic             an_we;
  logic [NW+LW-1:0] an_wa, an_ra0, an_ra1;
  logic [IdW-1:0]   an_wd, an_rd0_q, an_rd1_q, an0, an1;
  logic             an_z0_q, an_z1_q;

  always_ff @(posedge clk_i) begin
    if (nd_we) nd_mem[nd_wa] <= nd_wd;
    nd_rd0_q <= nd_mem[nd_ra0];
    nd_rd1_q <= nd_mem[nd_ra1];
    nd_z0_q  <= (nd_ra0 == '0);
    nd_z1_q  <= (nd_ra1 == '0);
  end

  always_ff @(posedge clk_i) begin
    if (an_we) an_mem[an_wa] <= an_wd;
    an_rd0_q <= an_mem[an_ra0];
    an_rd1_q <= an_mem[an_ra1];
    an_z0_q  <= (an_ra0[NW+LW-1:LW] == '0);
    an_z1_q  <= (an_ra1[NW+LW-1:LW] == '0);
  end

  // sentinel node 0 reads as zero
  assign nd0 = nd_z0_q ? '0 : nd_rd0_q;
  assign nd1 = nd_z1_q ? '0 : nd_rd1_q;
  assign an0 = an_z0_q ? '0 : an_rd0_q;
  assign an1 = an_z1_q ? '0 : an_rd1_q;

  // ---------------- sequencer ----------------
  logic [3:0]      state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic [NW-1:0]   u_q, u_d, cur_q, cur_d, a_q, a_d, b_q, b_d, t_q, t_d, l_q, l_d;
  logic [IdW-1:0]  w_q, w_d, db_q, db_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic [IdW-1:0]  ca_q, ca_d;
  logic [SumW-1:0] ps_q, ps_d;

  logic [NW-1:0]   ta, tb, qa, qb;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    u_d = u_q;  cur_d = cur_q;  a_d = a_q;  b_d = b_q;
    t_d = t_q;  l_d = l_q;  w_d = w_q;  db_d = db_q;
    sum_d = sum_q;  lvl_d = lvl_q;  ca_d = ca_q;  ps_d = ps_q;
    nd_we = 1'b0;  nd_wa = u_q;  nd_wd = '0;  nd_ra0 = '0;  nd_ra1 = '0;
    an_we = 1'b0;  an_wa = '0;   an_wd = '0;  an_ra0 = '0;  an_ra1 = '0;
    ta = clamp_id(an0);
    tb = clamp_id(an1);
    qa = clamp_id(node_a_i);
    qb = clamp_id(node_b_i);

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!action_i) begin
            u_d    = qa;
            cur_d  = clamp_id(parent_node_i);
            w_d    = node_weight_i;
            nd_ra0 = clamp_id(parent_node_i);
            // node 0 and ids out of range are dropped
            if (qa != '0) state_d = S_LD_PAR;
          end else begin
            a_d     = qa;
            b_d     = qb;
            nd_ra0  = qa;
            nd_ra1  = qb;
            state_d = S_Q_DEP;
          end
        end
      end

      S_LD_PAR: begin
        nd_we        = 1'b1;
        nd_wa        = u_q;
        nd_wd.depth  = nd0.depth + 1'b1;
        nd_wd.own    = w_q;
        nd_wd.prefix = (cur_q == '0) ? '0 : nd0.prefix + PfxW'(w_q);
        an_we        = 1'b1;
        an_wa        = {u_q, LW'(0)};
        an_wd        = to_id(cur_q);
        lvl_d        = LW'(1);
        state_d      = S_LD_ISS;
      end

      S_LD_ISS: begin
        an_ra0  = {cur_q, lvl_q - 1'b1};
        state_d = S_LD_WR;
      end

      S_LD_WR: begin
        an_we = 1'b1;
        an_wa = {u_q, lvl_q};
        an_wd = an0;
        cur_d = ta;
        if (lvl_q == LvlTop) begin
          state_d = S_IDLE;
        end else begin
          lvl_d   = lvl_q + 1'b1;
          state_d = S_LD_ISS;
        end
      end

      S_Q_DEP: begin
        sum_d = SumW'(nd0.prefix) + SumW'(nd1.prefix);
        lvl_d = LvlTop;
        // a_q becomes the deeper endpoint
        if (nd0.depth < nd1.depth) begin
          a_d  = b_q;
          b_d  = a_q;
          db_d = nd0.depth;
        end else begin
          db_d = nd1.depth;
        end
        an_ra0  = {a_d, LvlTop};
        state_d = S_Q_UP1;
      end

      S_Q_UP1: begin
        t_d     = ta;
        nd_ra0  = ta;
        state_d = S_Q_UP2;
      end

      S_Q_UP2: begin
        if (nd0.depth >= db_q) a_d = t_q;
        if (lvl_q == '0) begin
          state_d = S_Q_CMP;
        end else begin
          lvl_d   = lvl_q - 1'b1;
          an_ra0  = {a_d, lvl_q - 1'b1};
          state_d = S_Q_UP1;
        end
      end

      S_Q_CMP: begin
        if (a_q == b_q) begin
          l_d     = a_q;
          nd_ra0  = a_q;
          state_d = S_Q_FIN;
        end else begin
          lvl_d   = LvlTop;
          an_ra0  = {a_q, LvlTop};
          an_ra1  = {b_q, LvlTop};
          state_d = S_Q_DN;
        end
      end

      S_Q_DN: begin
        if (ta != tb) begin
          a_d = ta;
          b_d = tb;
        end
        if (lvl_q == '0) begin
          an_ra0  = {a_d, LW'(0)};
          state_d = S_Q_TOP;
        end else begin
          lvl_d  = lvl_q - 1'b1;
          an_ra0 = {a_d, lvl_q - 1'b1};
          an_ra1 = {b_d, lvl_q - 1'b1};
        end
      end

      S_Q_TOP: begin
        l_d     = ta;
        nd_ra0  = ta;
        state_d = S_Q_FIN;
      end

      S_Q_FIN: begin
        nd_ra0 = l_q;  // keep record in the read register while stalled
        if (!out_valid_q || !out_stall_i) begin
          ca_d        = to_id(l_q);
          ps_d        = sum_q - {nd0.prefix, 1'b0} + SumW'(nd0.own);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;    cur_q <= cur_d;  a_q  <= a_d;   b_q   <= b_d;
    t_q   <= t_d;    l_q   <= l_d;    w_q  <= w_d;   db_q  <= db_d;
    sum_q <= sum_d;  lvl_q <= lvl_d;  ca_q <= ca_d;  ps_q  <= ps_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign common_ancestor_o = ca_q;
  assign path_sum_o        = ps_q;

endmodule
